// ----- rtl/tcfe_pkg.sv -----
// package: types, constants and state encoding shared by the tile cache files
`default_nettype none
package tcfe_pkg;

   localparam int CACHE_ENTRIES_DEFAULT = 64;
   localparam int TAG_W = 32;
   localparam int COORD_W = 32;
   localparam int SLOT_INDEX_W = 6;
   localparam int MAG_W = COORD_W;
   localparam int SUM_W = MAG_W + 2;
   localparam int DIST_W = MAG_W + 3;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_DECIDE,
      ST_CLEAR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [COORD_W-1:0] center_z;
   } slot_entry_type;

   typedef struct packed {
      logic             last;
      logic             ent_valid;
      logic             match;
      logic [TAG_W-1:0] tag;
   } scan_info_type;

endpackage
`default_nettype wire

// ----- rtl/tcfe_slot_ram.sv -----
// slot storage: one write port, one registered read port
`default_nettype none
module tcfe_slot_ram #(
   parameter int Depth = tcfe_pkg::CACHE_ENTRIES_DEFAULT,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AddrWidth-1:0]    wr_addr,
   input  wire tcfe_pkg::slot_entry_type wr_data,
   input  wire logic                    rd_en,
   input  wire logic [AddrWidth-1:0]    rd_addr,
   output tcfe_pkg::slot_entry_type     rd_data
);

   tcfe_pkg::slot_entry_type mem_ff [Depth];
   tcfe_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/tcfe_dist_unit.sv -----
// pipelined distance unit: 4*max + med + min of per-axis magnitudes, three stages
`default_nettype none
module tcfe_dist_unit #(
   parameter int IdxWidth = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire tcfe_pkg::scan_info_type       in_info,
   input  wire logic [IdxWidth-1:0]           in_idx,
   input  wire logic [tcfe_pkg::COORD_W-1:0]  center_x,
   input  wire logic [tcfe_pkg::COORD_W-1:0]  center_y,
   input  wire logic [tcfe_pkg::COORD_W-1:0]  center_z,
   input  wire logic [tcfe_pkg::COORD_W-1:0]  view_x,
   input  wire logic [tcfe_pkg::COORD_W-1:0]  view_y,
   input  wire logic [tcfe_pkg::COORD_W-1:0]  view_z,
   output logic                               out_valid,
   output tcfe_pkg::scan_info_type            out_info,
   output logic [IdxWidth-1:0]                out_idx,
   output logic [tcfe_pkg::DIST_W-1:0]        out_dist
);

   localparam int CW = tcfe_pkg::COORD_W;
   localparam int MW = tcfe_pkg::MAG_W;
   localparam int SW = tcfe_pkg::SUM_W;
   localparam int DW = tcfe_pkg::DIST_W;

   function automatic logic [MW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] d;
      logic [CW:0] n;
      begin
         d = {a[CW-1], a} - {b[CW-1], b};
         n = ~d + (CW+1)'(1);
         abs_diff = d[CW] ? n[MW-1:0] : d[MW-1:0];
      end
   endfunction

   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff;
   tcfe_pkg::scan_info_type s1_info_ff, s2_info_ff, s3_info_ff;
   logic [IdxWidth-1:0]     s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [MW-1:0]           s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [MW-1:0]           s2_max_ff;
   logic [SW-1:0]           s2_sum_ff;
   logic [DW-1:0]           s3_dist_ff;

   logic [MW-1:0] max_xy_in;
   logic [MW-1:0] s2_max_in;
   logic [SW-1:0] s2_sum_in;
   logic [DW-1:0] s3_dist_in;

   always_comb begin
      max_xy_in = (s1_dx_ff < s1_dy_ff) ? s1_dy_ff : s1_dx_ff;
      s2_max_in = (max_xy_in < s1_dz_ff) ? s1_dz_ff : max_xy_in;
      s2_sum_in = SW'(s1_dx_ff) + SW'(s1_dy_ff) + SW'(s1_dz_ff);
      // 4*max + med + min = 3*max + (dx + dy + dz)
      s3_dist_in = DW'({s2_max_ff, 1'b0}) + DW'(s2_max_ff) + DW'(s2_sum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_info_ff <= in_info;
      s1_idx_ff  <= in_idx;
      s1_dx_ff   <= abs_diff(center_x, view_x);
      s1_dy_ff   <= abs_diff(center_y, view_y);
      s1_dz_ff   <= abs_diff(center_z, view_z);
      s2_info_ff <= s1_info_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_max_ff  <= s2_max_in;
      s2_sum_ff  <= s2_sum_in;
      s3_info_ff <= s2_info_ff;
      s3_idx_ff  <= s2_idx_ff;
      s3_dist_ff <= s3_dist_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_info  = s3_info_ff;
   assign out_idx   = s3_idx_ff;
   assign out_dist  = s3_dist_ff;

endmodule
`default_nettype wire

// ----- rtl/tile_cache_farthest_eviction_core.sv -----
// top level: fully associative tile cache with farthest-slot eviction
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_ready | kind, tile_tag, view_x/y/z, center_x/y/z
//   rsp     | out | rsp_valid/rsp_ready | slot_index, hit, evicted, evicted_tag
//
// a lookup reads one slot per cycle from the slot ram, passes each through the
// three distance stages, then decides and installs in ST_DECIDE
// a clear request sweeps the ram, writing every slot invalid
// after reset a clearing pass over every slot runs before req_ready rises
// req_ready stays high in idle while the registered response waits on rsp_ready
`default_nettype none
module tile_cache_farthest_eviction_core #(
   parameter int CacheEntries = tcfe_pkg::CACHE_ENTRIES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_kind,
   input  wire logic [tcfe_pkg::TAG_W-1:0]          req_tile_tag,
   input  wire logic signed [tcfe_pkg::COORD_W-1:0] req_view_x,
   input  wire logic signed [tcfe_pkg::COORD_W-1:0] req_view_y,
   input  wire logic signed [tcfe_pkg::COORD_W-1:0] req_view_z,
   input  wire logic signed [tcfe_pkg::COORD_W-1:0] req_center_x,
   input  wire logic signed [tcfe_pkg::COORD_W-1:0] req_center_y,
   input  wire logic signed [tcfe_pkg::COORD_W-1:0] req_center_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [tcfe_pkg::SLOT_INDEX_W-1:0]        rsp_slot_index,
   output logic                                     rsp_hit,
   output logic                                     rsp_evicted,
   output logic [tcfe_pkg::TAG_W-1:0]               rsp_evicted_tag
);

   localparam int IW = $clog2(CacheEntries);
   localparam int CW = tcfe_pkg::COORD_W;
   localparam int TW = tcfe_pkg::TAG_W;
   localparam int DW = tcfe_pkg::DIST_W;
   localparam int OW = tcfe_pkg::SLOT_INDEX_W;
   localparam logic [IW-1:0] LastIdx = IW'(CacheEntries - 1);

   tcfe_pkg::state_type state_ff, state_in;
   logic [IW-1:0]       cnt_ff, cnt_in;

   logic [TW-1:0] tag_ff;
   logic [CW-1:0] view_x_ff, view_y_ff, view_z_ff;
   logic [CW-1:0] center_x_ff, center_y_ff, center_z_ff;

   logic          hit_found_ff, hit_found_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic [DW-1:0] best_d_ff, best_d_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [TW-1:0] best_tag_ff, best_tag_in;

   logic          res_hit_ff, res_hit_in;
   logic          res_ev_ff, res_ev_in;
   logic [IW-1:0] res_idx_ff, res_idx_in;
   logic [TW-1:0] res_tag_ff, res_tag_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_idx_ff, rsp_idx_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic          rsp_ev_ff, rsp_ev_in;
   logic [TW-1:0] rsp_tag_ff, rsp_tag_in;

   logic          rd_vld_ff, rd_vld_in;
   logic          rd_last_ff, rd_last_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;

   logic                     accept;
   logic                     cnt_last;
   logic                     rsp_free;
   logic                     ram_wr_en;
   logic [IW-1:0]            ram_wr_addr;
   tcfe_pkg::slot_entry_type ram_wr_data;
   logic                     ram_rd_en;
   tcfe_pkg::slot_entry_type ram_rd_data;
   tcfe_pkg::scan_info_type  scan_info;
   logic                     du_valid;
   tcfe_pkg::scan_info_type  du_info;
   logic [IW-1:0]            du_idx;
   logic [DW-1:0]            du_dist;
   logic [IW-1:0]            pick_idx;

   assign accept   = req_valid && req_ready;
   assign cnt_last = (cnt_ff == LastIdx);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   tcfe_slot_ram #(
      .Depth     (CacheEntries),
      .AddrWidth (IW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      scan_info.last      = rd_last_ff;
      scan_info.ent_valid = ram_rd_data.valid;
      scan_info.match     = ram_rd_data.valid && (ram_rd_data.tag == tag_ff);
      scan_info.tag       = ram_rd_data.tag;
   end

   tcfe_dist_unit #(
      .IdxWidth (IW)
   ) u_dist_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_vld_ff),
      .in_info   (scan_info),
      .in_idx    (rd_idx_ff),
      .center_x  (ram_rd_data.center_x),
      .center_y  (ram_rd_data.center_y),
      .center_z  (ram_rd_data.center_z),
      .view_x    (view_x_ff),
      .view_y    (view_y_ff),
      .view_z    (view_z_ff),
      .out_valid (du_valid),
      .out_info  (du_info),
      .out_idx   (du_idx),
      .out_dist  (du_dist)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcfe_pkg::ST_INIT: begin
            if (cnt_last) begin
               state_in = tcfe_pkg::ST_IDLE;
            end
         end
         tcfe_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == tcfe_pkg::KIND_CLEAR) ? tcfe_pkg::ST_CLEAR
                                                               : tcfe_pkg::ST_SCAN;
            end
         end
         tcfe_pkg::ST_SCAN: begin
            if (cnt_last) begin
               state_in = tcfe_pkg::ST_WAIT;
            end
         end
         tcfe_pkg::ST_WAIT: begin
            if (du_valid && du_info.last) begin
               state_in = tcfe_pkg::ST_DECIDE;
            end
         end
         tcfe_pkg::ST_DECIDE: begin
            state_in = tcfe_pkg::ST_RESP;
         end
         tcfe_pkg::ST_CLEAR: begin
            if (cnt_last) begin
               state_in = tcfe_pkg::ST_RESP;
            end
         end
         tcfe_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = tcfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcfe_pkg::ST_INIT;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff;
      ram_wr_data.valid    = 1'b0;
      ram_wr_data.tag      = tag_ff;
      ram_wr_data.center_x = center_x_ff;
      ram_wr_data.center_y = center_y_ff;
      ram_wr_data.center_z = center_z_ff;
      cnt_in      = '0;
      rd_vld_in   = 1'b0;
      rd_last_in  = 1'b0;
      rd_idx_in   = cnt_ff;
      res_hit_in  = res_hit_ff;
      res_ev_in   = res_ev_ff;
      res_idx_in  = res_idx_ff;
      res_tag_in  = res_tag_ff;
      pick_idx    = hit_found_ff ? hit_idx_ff : (free_found_ff ? free_idx_ff : best_idx_ff);
      case (state_ff)
         tcfe_pkg::ST_INIT, tcfe_pkg::ST_CLEAR: begin
            ram_wr_en  = 1'b1;
            cnt_in     = cnt_last ? '0 : cnt_ff + IW'(1);
            res_hit_in = 1'b0;
            res_ev_in  = 1'b0;
            res_idx_in = '0;
            res_tag_in = '0;
         end
         tcfe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         tcfe_pkg::ST_SCAN: begin
            ram_rd_en  = 1'b1;
            rd_vld_in  = 1'b1;
            rd_last_in = cnt_last;
            cnt_in     = cnt_last ? '0 : cnt_ff + IW'(1);
         end
         tcfe_pkg::ST_DECIDE: begin
            ram_wr_en         = !hit_found_ff;
            ram_wr_addr       = pick_idx;
            ram_wr_data.valid = 1'b1;
            res_hit_in        = hit_found_ff;
            res_ev_in         = !hit_found_ff && !free_found_ff;
            res_idx_in        = pick_idx;
            res_tag_in        = (!hit_found_ff && !free_found_ff) ? best_tag_ff : '0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // scan tracking: first match, first free slot, farthest valid slot
   always_comb begin
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_d_in     = best_d_ff;
      best_idx_in   = best_idx_ff;
      best_tag_in   = best_tag_ff;
      if (accept) begin
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         best_d_in     = '0;
         best_idx_in   = '0;
      end else if (du_valid) begin
         if (du_info.match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = du_idx;
         end
         if (!du_info.ent_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = du_idx;
         end
         if (du_info.ent_valid && ((du_idx == '0) || (du_dist > best_d_ff))) begin
            best_d_in   = du_dist;
            best_idx_in = du_idx;
            best_tag_in = du_info.tag;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_tag_in   = rsp_tag_ff;
      if ((state_ff == tcfe_pkg::ST_RESP) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = OW'(res_idx_ff);
         rsp_hit_in   = res_hit_ff;
         rsp_ev_in    = res_ev_ff;
         rsp_tag_in   = res_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcfe_pkg::ST_INIT;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
      end
      rd_last_ff  <= rd_last_in;
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      best_tag_ff <= best_tag_in;
      res_hit_ff  <= res_hit_in;
      res_ev_ff   <= res_ev_in;
      res_idx_ff  <= res_idx_in;
      res_tag_ff  <= res_tag_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_tag_ff  <= rsp_tag_in;
      if (accept) begin
         tag_ff      <= req_tile_tag;
         view_x_ff   <= req_view_x;
         view_y_ff   <= req_view_y;
         view_z_ff   <= req_view_z;
         center_x_ff <= req_center_x;
         center_y_ff <= req_center_y;
         center_z_ff <= req_center_z;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot_index  = rsp_idx_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_evicted     = rsp_ev_ff;
   assign rsp_evicted_tag = rsp_tag_ff;

endmodule
`default_nettype wire
